// ===== hdl/pfba_pkg.sv =====
// Shared types, codes and constants of the page frame bitmap allocator.
package pfba_pkg;

    // Default bitmap depth in 32-page words
    localparam int MAX_WORDS_DEF = 2048;

    // Register and field widths fixed by the interface
    localparam int RAM_WORDS_W   = 12;
    localparam int COUNT_W       = 17;
    localparam int ADDR_W        = 32;
    localparam int WORD_IDX_W    = 14;
    localparam int M_DATA_W      = 56;
    localparam int M_USER_W      = 2;

    // Reset value of ram_words
    localparam logic [RAM_WORDS_W-1:0] RAM_WORDS_RST = 12'd2048;

    // Base address of RAM and saturation limit of the free count
    localparam logic [ADDR_W-1:0]  RAM_BASE  = 32'h8000_0000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1_FFFF;

    // Command codes
    typedef enum logic [1:0] {
        CMD_QUERY  = 2'd0,
        CMD_USED   = 2'd1,
        CMD_UNUSED = 2'd2,
        CMD_REINIT = 2'd3
    } cmd_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_CLEAR,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/pfba_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module pfba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register the read data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/page_frame_bitmap_allocator_core.sv =====
// Page frame bitmap allocator: sequencer around one bitmap RAM.
//
//  Channel | Direction | Handshake         | Payload
//  --------+-----------+-------------------+-----------------------------------------
//  s_      | in        | s_tvalid/s_tready | tdata: frame_addr; tuser: cmd
//  m_      | out       | m_tvalid/m_tready | tdata: free_address, free_count;
//          |           |                   | tuser: found, status
//  cfg_    | in        | cfg_valid/ready   | cfg_data: ram_words
//
// A query or a rejected mark goes straight to result loading. A mark in range writes the
// bit, then runs the lowest-free scan over k words (1 .. ram_words after saturation),
// one word per cycle through the RAM read port. Reinitialise clears all MAX_WORDS words,
// the sweep writing one word per cycle, then loads its result. After reset the same sweep
// runs before the first item is accepted; configuration is taken meanwhile.
// One item is in work at a time; a result held by m_tready stalls only the final step.
module page_frame_bitmap_allocator_core #(
    parameter int MAX_WORDS = pfba_pkg::MAX_WORDS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Input item: tdata[31:0] frame_addr
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [pfba_pkg::ADDR_W-1:0]           s_tdata,
    // Input item: tuser[1:0] cmd
    input  logic [1:0]                            s_tuser,
    // Result item: tdata[31:0] free_address, [48:32] free_count, [55:49] zero
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [pfba_pkg::M_DATA_W-1:0]         m_tdata,
    // Result item: tuser[0] found, [1] status
    output logic [pfba_pkg::M_USER_W-1:0]         m_tuser,
    // Configuration: ram_words
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pfba_pkg::RAM_WORDS_W-1:0]      cfg_data
);

    import pfba_pkg::*;

    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int XW = (AW > WORD_IDX_W) ? AW : WORD_IDX_W;
    localparam int RST_EFF = (int'(RAM_WORDS_RST) > MAX_WORDS) ? MAX_WORDS
                                                               : int'(RAM_WORDS_RST);
    localparam logic [COUNT_W-1:0] RST_COUNT = COUNT_W'(RST_EFF * 32);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_WORDS - 1);

    // Lowest clear bit of a bitmap word
    function automatic logic [4:0] low_zero(input logic [31:0] w);
        logic [4:0] b;
        b = '0;
        for (int i = 31; i >= 0; i--) begin
            if (!w[i]) begin
                b = 5'(i);
            end
        end
        return b;
    endfunction

    state_t                 state_reg, state_next;
    logic                   reinit_reg, reinit_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [4:0]             bit_reg, bit_next;
    logic [AW-1:0]          word_reg, word_next;
    logic                   status_reg, status_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [AW-1:0]          nfw_reg, nfw_next;
    logic [4:0]             nfb_reg, nfb_next;
    logic [AW-1:0]          rd_idx_reg, rd_idx_next;
    logic [AW-1:0]          chk_idx_reg, chk_idx_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [AW-1:0]          clr_idx_reg, clr_idx_next;
    logic [RAM_WORDS_W-1:0] ram_words_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]    m_data_reg, m_data_next;
    logic [M_USER_W-1:0]    m_user_reg, m_user_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [31:0]            ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [31:0]            ram_rdata;

    logic [RAM_WORDS_W-1:0] eff_words;
    logic [XW-1:0]          in_word;
    logic                   in_accept;
    logic [31:0]            mask;
    logic                   found;
    logic [ADDR_W-1:0]      free_addr;

    // Saturate ram_words to 1 .. MAX_WORDS
    always_comb begin
        if (ram_words_reg == '0) begin
            eff_words = RAM_WORDS_W'(1);
        end else if (32'(ram_words_reg) > MAX_WORDS) begin
            eff_words = RAM_WORDS_W'(MAX_WORDS);
        end else begin
            eff_words = ram_words_reg;
        end
    end

    assign in_word   = XW'(s_tdata[30:17]);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign mask      = 32'd1 << bit_reg;
    assign found     = (count_reg != '0);
    assign free_addr = found ? (RAM_BASE + ((32'(nfw_reg) & 32'h0000_3FFF) << 17)
                               + (32'(nfb_reg) << 12)) : '0;

    // Bitmap store
    pfba_ram #(
        .WIDTH (32),
        .DEPTH (MAX_WORDS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer: next state, RAM access and result loading
    always_comb begin
        state_next   = state_reg;
        reinit_next  = reinit_reg;
        cmd_next     = cmd_reg;
        bit_next     = bit_reg;
        word_next    = word_reg;
        status_next  = status_reg;
        count_next   = count_reg;
        nfw_next     = nfw_reg;
        nfb_next     = nfb_reg;
        rd_idx_next  = rd_idx_reg;
        chk_idx_next = chk_idx_reg;
        chk_vld_next = chk_vld_reg;
        clr_idx_next = clr_idx_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        ram_we       = 1'b0;
        ram_waddr    = word_reg;
        ram_wdata    = '0;
        ram_raddr    = word_reg;

        unique case (state_reg)
            ST_IDLE: begin
                ram_raddr = in_word[AW-1:0];
                if (in_accept) begin
                    cmd_next    = cmd_t'(s_tuser);
                    bit_next    = s_tdata[16:12];
                    word_next   = in_word[AW-1:0];
                    status_next = 1'b0;
                    unique case (cmd_t'(s_tuser))
                        CMD_QUERY: begin
                            state_next = ST_DONE;
                        end
                        CMD_REINIT: begin
                            count_next   = {eff_words, 5'b0};
                            nfw_next     = '0;
                            nfb_next     = '0;
                            clr_idx_next = '0;
                            reinit_next  = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                        CMD_USED, CMD_UNUSED: begin
                            if (in_word >= XW'(eff_words)) begin
                                status_next = 1'b1;
                                state_next  = ST_DONE;
                            end else begin
                                state_next = ST_MOD;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MOD: begin
                // Set or clear the bit, adjust the count only on a real change
                ram_we = 1'b1;
                if (cmd_reg == CMD_USED) begin
                    ram_wdata = ram_rdata | mask;
                    if ((ram_rdata & mask) == '0 && count_reg != '0) begin
                        count_next = count_reg - 1'b1;
                    end
                end else begin
                    ram_wdata = ram_rdata & ~mask;
                    if ((ram_rdata & mask) != '0 && count_reg != COUNT_MAX) begin
                        count_next = count_reg + 1'b1;
                    end
                end
                rd_idx_next  = '0;
                chk_vld_next = 1'b0;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                // Issue one word read per cycle, check the word read last cycle
                ram_raddr    = rd_idx_reg;
                rd_idx_next  = rd_idx_reg + 1'b1;
                chk_idx_next = rd_idx_reg;
                chk_vld_next = 1'b1;
                if (chk_vld_reg) begin
                    if (ram_rdata != 32'hFFFF_FFFF) begin
                        nfw_next     = chk_idx_reg;
                        nfb_next     = low_zero(ram_rdata);
                        chk_vld_next = 1'b0;
                        state_next   = ST_DONE;
                    end else if ((32'(chk_idx_reg) + 32'd1) == 32'(eff_words)) begin
                        chk_vld_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_CLEAR: begin
                // Sweep zeros over every word
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                ram_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX) begin
                    reinit_next = 1'b0;
                    state_next  = reinit_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                // Load the result once the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_DATA_W'({count_reg, free_addr});
                    m_user_next  = {status_reg, found};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            reinit_reg    <= 1'b0;
            clr_idx_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            count_reg     <= RST_COUNT;
            nfw_reg       <= '0;
            nfb_reg       <= '0;
            ram_words_reg <= RAM_WORDS_RST;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            reinit_reg  <= reinit_next;
            clr_idx_reg <= clr_idx_next;
            chk_vld_reg <= chk_vld_next;
            count_reg   <= count_next;
            nfw_reg     <= nfw_next;
            nfb_reg     <= nfb_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                ram_words_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        bit_reg     <= bit_next;
        word_reg    <= word_next;
        status_reg  <= status_next;
        rd_idx_reg  <= rd_idx_next;
        chk_idx_reg <= chk_idx_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // A result without a free page carries a zero address
    a_no_free_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[31:0] == '0))
        else $error("free_address not zero while found is clear");

    // A result with a free page points into RAM
    a_free_in_ram: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tdata[31])
        else $error("free_address outside RAM");

    // The bitmap is written only by a mark update or the clearing sweep
    a_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_MOD || state_reg == ST_CLEAR))
        else $error("bitmap written outside update or sweep");

    // A query goes straight to result loading
    a_query_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_tuser == CMD_QUERY) |=> (state_reg == ST_DONE))
        else $error("query did not go to result loading");

    // A reinitialise leaves the free position at zero
    a_reinit_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_tuser == CMD_REINIT) |=> (nfw_reg == '0 && nfb_reg == '0))
        else $error("reinitialise did not reset the free position");

endmodule
